// ----- src/wnm_pkg.sv -----
// ----------------------------------------------------------------------------
// wnm_pkg
// Shared types for the window nearest-to-mean position filter.
// ----------------------------------------------------------------------------
package wnm_pkg;

  localparam int unsigned SampleW = 24;

  typedef logic [SampleW-1:0] sample_t;

  typedef struct packed {
    sample_t x_sample;
    sample_t y_sample;
  } in_item_t;

  typedef struct packed {
    sample_t filtered_x;
    sample_t filtered_y;
  } out_item_t;

  // control from the top level to each coordinate lane
  typedef struct packed {
    logic start;  // new sample arrives
    logic full;   // window already held WINDOW samples before this one
    logic take;   // merge stage consumes the held result
  } lane_cmd_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } lane_stat_t;

endpackage

// ----- src/wnm_div.sv -----
// ----------------------------------------------------------------------------
// wnm_div
// Divide by a constant through reciprocal multiplication: the dividend is
// registered at start and the quotient is ready in the cycle after.
// ----------------------------------------------------------------------------
module wnm_div #(
  parameter int unsigned DIVIDEND_W = 29,
  parameter int unsigned DIVISOR    = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quot_o
);

  // floor(x / DIVISOR) == (x * Recip) >> Shift for every x below 2**DIVIDEND_W
  localparam int unsigned     Shift  = DIVIDEND_W + $clog2(DIVISOR);
  localparam int unsigned     RecipW = DIVIDEND_W + 1;
  localparam int unsigned     ProdW  = DIVIDEND_W + RecipW;
  localparam longint unsigned RecipL =
    ((64'd1 << Shift) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);

  logic                  done_q;
  logic [DIVIDEND_W-1:0] dvd_q;
  logic [ProdW-1:0]      prod;

  assign prod = {{RecipW{1'b0}}, dvd_q} * {{DIVIDEND_W{1'b0}}, Recip};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = DIVIDEND_W'(prod >> Shift);

endmodule

// ----- src/wnm_lane.sv -----
// ----------------------------------------------------------------------------
// wnm_lane
// One coordinate: sliding window, running sum, mean, deviation ranking and
// average of the KEEP entries closest to the mean.
// ----------------------------------------------------------------------------
module wnm_lane #(
  parameter int unsigned WINDOW = 20,
  parameter int unsigned KEEP   = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wnm_pkg::lane_cmd_t    cmd_i,
  input  wnm_pkg::sample_t      sample_i,
  output wnm_pkg::lane_stat_t   stat_o,
  output wnm_pkg::sample_t      result_o
);
  import wnm_pkg::*;

  localparam int unsigned IdxW  = $clog2(WINDOW);
  localparam int unsigned SumW  = SampleW + $clog2(WINDOW);
  localparam int unsigned RankW = $clog2(WINDOW + 1);

  localparam logic [2:0] L_IDLE  = 3'd0;
  localparam logic [2:0] L_MEAN  = 3'd1;
  localparam logic [2:0] L_DEV   = 3'd2;
  localparam logic [2:0] L_RANK  = 3'd3;
  localparam logic [2:0] L_DRAIN = 3'd4;
  localparam logic [2:0] L_FDIV  = 3'd5;
  localparam logic [2:0] L_HOLD  = 3'd6;

  function automatic sample_t absdiff(input sample_t a, input sample_t b);
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

  logic [2:0]        state_q, state_d;
  sample_t           win_q [WINDOW];
  sample_t           dev_q [WINDOW];
  logic [SumW-1:0]   sum_q, sum_d;
  sample_t           mean_q;
  logic [WINDOW-1:0] less_q, less_d;
  sample_t           val_q;
  logic              pend_q;
  logic [IdxW-1:0]   cnt_q;
  logic [SumW-1:0]   acc_q, acc_d;
  sample_t           res_q;
  sample_t           cur_dev;
  logic [RankW-1:0]  rank;
  logic              keep_hit;
  logic              shift_in;

  logic              mean_start;
  logic              mean_done;
  logic [SumW-1:0]   mean_quot;
  logic              avg_start;
  logic              avg_done;
  logic [SumW-1:0]   avg_quot;

  assign shift_in = (state_q == L_IDLE) && cmd_i.start;

  // running window sum; the oldest entry drops out once the window is full
  always_comb begin
    sum_d = sum_q;
    if (shift_in) begin
      sum_d = sum_q + SumW'(sample_i)
            - (cmd_i.full ? SumW'(win_q[WINDOW-1]) : SumW'(0));
    end
  end

  // ranking: tap 0 of the rotating window holds entry cnt_q (newest first)
  always_comb begin
    cur_dev = absdiff(win_q[0], mean_q);
    for (int j = 0; j < WINDOW; j++) begin
      less_d[j] = (dev_q[j] < cur_dev) ||
                  ((dev_q[j] == cur_dev) && (IdxW'(j) < cnt_q));
    end
  end

  assign rank     = RankW'($countones(less_q));
  assign keep_hit = pend_q && (32'(rank) < KEEP);
  assign acc_d    = acc_q + (keep_hit ? SumW'(val_q) : SumW'(0));

  assign mean_start = shift_in && cmd_i.full;
  assign avg_start  = (state_q == L_DRAIN);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE: begin
        if (cmd_i.start && cmd_i.full) begin
          state_d = L_MEAN;
        end
      end
      L_MEAN: begin
        if (mean_done) begin
          state_d = L_DEV;
        end
      end
      L_DEV: begin
        state_d = L_RANK;
      end
      L_RANK: begin
        if (cnt_q == IdxW'(WINDOW - 1)) begin
          state_d = L_DRAIN;
        end
      end
      L_DRAIN: begin
        state_d = L_FDIV;
      end
      L_FDIV: begin
        if (avg_done) begin
          state_d = L_HOLD;
        end
      end
      L_HOLD: begin
        if (cmd_i.take) begin
          state_d = L_IDLE;
        end
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_in) begin
      win_q[0] <= sample_i;
      for (int k = 1; k < WINDOW; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
    if ((state_q == L_MEAN) && mean_done) begin
      mean_q <= mean_quot[SampleW-1:0];
    end
    if (state_q == L_DEV) begin
      for (int k = 0; k < WINDOW; k++) begin
        dev_q[k] <= absdiff(win_q[k], mean_q);
      end
      cnt_q  <= '0;
      acc_q  <= '0;
      pend_q <= 1'b0;
    end
    if (state_q == L_RANK) begin
      // a full rotation through all WINDOW entries leaves the window in its original order
      for (int k = 0; k < WINDOW - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[WINDOW-1] <= win_q[0];
      less_q <= less_d;
      val_q  <= win_q[0];
      pend_q <= 1'b1;
      acc_q  <= acc_d;
      cnt_q  <= cnt_q + 1'b1;
    end
    if ((state_q == L_FDIV) && avg_done) begin
      res_q <= avg_quot[SampleW-1:0];
    end
  end

  wnm_div #(
    .DIVIDEND_W (SumW),
    .DIVISOR    (WINDOW)
  ) u_div_mean (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mean_start),
    .dividend_i (sum_d),
    .done_o     (mean_done),
    .quot_o     (mean_quot)
  );

  wnm_div #(
    .DIVIDEND_W (SumW),
    .DIVISOR    (KEEP)
  ) u_div_avg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (avg_start),
    .dividend_i (acc_d),
    .done_o     (avg_done),
    .quot_o     (avg_quot)
  );

  assign stat_o.idle      = (state_q == L_IDLE);
  assign stat_o.res_valid = (state_q == L_HOLD);
  assign result_o         = res_q;

endmodule

// ----- src/window_nearest_to_mean_filter.sv -----
// ----------------------------------------------------------------------------
// window_nearest_to_mean_filter
// X/Y position smoother: mean of the KEEP window entries nearest the window
// mean, one lane per coordinate, results merged into one output register.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_valid_i/in_ready_o  in_data_i  (x_sample, y_sample)
//  out      out  out_valid_o/out_ready_i out_data_o (filtered_x, filtered_y)
//
//  While the window fills, a transfer yields no result and the input stays ready.
//  Once full, an item holds the input until its result moves on: mean by
//  reciprocal multiply, all deviations at once, the rank pass one window entry
//  per cycle, then the final average by reciprocal multiply.
//  Reset clears the fill count and the running sums; window contents are not
//  cleared. A finished result waits in the lanes while the output register is
//  full, and the input stays stalled until it moves on.
module window_nearest_to_mean_filter #(
  parameter int unsigned WINDOW = 20,
  parameter int unsigned KEEP   = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wnm_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wnm_pkg::out_item_t  out_data_o
);
  import wnm_pkg::*;

  localparam int unsigned FillW = $clog2(WINDOW + 1);

  logic [FillW-1:0] fill_q;
  logic             full;
  logic             accept;
  logic             merge;
  logic             out_valid_q;
  out_item_t        out_q;
  lane_cmd_t        cmd;
  lane_stat_t       stat_x, stat_y;
  sample_t          res_x, res_y;

  assign full       = (fill_q == FillW'(WINDOW));
  assign in_ready_o = stat_x.idle && stat_y.idle;
  assign accept     = in_valid_i && in_ready_o;
  assign merge      = stat_x.res_valid && stat_y.res_valid &&
                      (!out_valid_q || out_ready_i);

  assign cmd.start = accept;
  assign cmd.full  = full;
  assign cmd.take  = merge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept && !full) begin
        fill_q <= fill_q + 1'b1;
      end
      if (merge) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (merge) begin
      out_q.filtered_x <= res_x;
      out_q.filtered_y <= res_y;
    end
  end

  wnm_lane #(
    .WINDOW (WINDOW),
    .KEEP   (KEEP)
  ) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sample_i (in_data_i.x_sample),
    .stat_o   (stat_x),
    .result_o (res_x)
  );

  wnm_lane #(
    .WINDOW (WINDOW),
    .KEEP   (KEEP)
  ) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sample_i (in_data_i.y_sample),
    .stat_o   (stat_y),
    .result_o (res_y)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives X/Y position samples into the window nearest-to-mean filter with
// random idling on both sides and checks every filtered output against a
// behavioral predictor of the sliding windows and the trimmed average.
// ----------------------------------------------------------------------------
module testbench;
  import wnm_pkg::*;

  localparam int unsigned WINDOW     = 20;
  localparam int unsigned KEEP       = 12;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned DRAIN_LEN  = 200;
  localparam longint      CYCLE_CAP  = 1000000;

  typedef logic [WINDOW-1:0][SampleW-1:0] window_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;

  // predictor state, index 0 holds the newest sample
  window_t    win_x;
  window_t    win_y;
  int         fill_level;
  out_item_t  filtered_q[$];

  int         errors;
  int         n_samples;
  int         n_filtered;
  longint     cycles;
  bit         no_idle;
  bit         hold_req;
  bit         holding;

  window_nearest_to_mean_filter #(
    .WINDOW (WINDOW),
    .KEEP   (KEEP)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("%0t: timeout, %0d results still pending", $time, filtered_q.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // average of the KEEP entries closest to the truncated window mean;
  // equal deviations rank the newer entry first
  function automatic sample_t nearest_to_mean(window_t w);
    longint unsigned total;
    longint unsigned kept;
    sample_t         avg;
    sample_t         dev [WINDOW];
    int              rank;
    total = 0;
    for (int i = 0; i < WINDOW; i++) total += w[i];
    avg = sample_t'(total / WINDOW);
    for (int i = 0; i < WINDOW; i++)
      dev[i] = (w[i] >= avg) ? w[i] - avg : avg - w[i];
    kept = 0;
    for (int i = 0; i < WINDOW; i++) begin
      rank = 0;
      for (int j = 0; j < WINDOW; j++)
        if (dev[j] < dev[i] || (dev[j] == dev[i] && j < i)) rank++;
      if (rank < KEEP) kept += w[i];
    end
    return sample_t'(kept / KEEP);
  endfunction

  function automatic void absorb_sample(in_item_t s);
    out_item_t r;
    bit        was_full;
    was_full = (fill_level >= WINDOW);
    win_x = {win_x[WINDOW-2:0], s.x_sample};
    win_y = {win_y[WINDOW-2:0], s.y_sample};
    n_samples++;
    if (!was_full) begin
      fill_level++;
    end else begin
      r.filtered_x = nearest_to_mean(win_x);
      r.filtered_y = nearest_to_mean(win_y);
      filtered_q.push_back(r);
    end
  endfunction

  // transfers are sampled at the rising edge; inputs only move on the falling one
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_filtered++;
        if (filtered_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result x=%h y=%h", $time,
                   out_data.filtered_x, out_data.filtered_y);
        end else begin
          want = filtered_q.pop_front();
          if (out_data.filtered_x !== want.filtered_x) begin
            errors++;
            $display("%0t: filtered_x expected %h got %h", $time,
                     want.filtered_x, out_data.filtered_x);
          end
          if (out_data.filtered_y !== want.filtered_y) begin
            errors++;
            $display("%0t: filtered_y expected %h got %h", $time,
                     want.filtered_y, out_data.filtered_y);
          end
        end
      end
      if (in_valid && in_ready) absorb_sample(in_data);
    end
  end

  // output side: short random stalls, or one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        holding = 1'b0;
        if (hold_req) begin
          stall_left = HOLD_LEN;
          holding    = 1'b1;
          hold_req   = 1'b0;
        end else if (!no_idle && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 10);
        end
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(sample_t x, sample_t y);
    int gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid           <= 1'b1;
    in_data.x_sample   <= x;
    in_data.y_sample   <= y;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic input_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (filtered_q.size() != 0) @(posedge clk);
  endtask

  function automatic sample_t jitter(sample_t center);
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) return sample_t'(center + $urandom_range(0, 6) - 3);
    if (mode < 8) return sample_t'($urandom);
    return $urandom_range(0, 1) ? '0 : '1;
  endfunction

  // window fill with no output, rail values, equal-deviation ties
  task automatic test_fill_and_extremes();
    for (int i = 0; i < WINDOW; i++)
      send_sample((i % 2) ? '1 : '0, (i % 2) ? 24'd1002 : 24'd1000);
    send_sample('0, '0);
    send_sample('1, '1);
    send_sample(24'h555555, 24'hAAAAAA);
    send_sample(24'hAAAAAA, 24'h555555);
    send_sample(24'h123456, 24'hFEDCBA);
  endtask

  // slowly moving tracks with noise, full-range samples and rail outliers
  task automatic test_random_tracks(int count);
    sample_t cx;
    sample_t cy;
    cx = sample_t'($urandom);
    cy = sample_t'($urandom);
    repeat (count) begin
      if ($urandom_range(0, 49) == 0) begin
        cx = sample_t'($urandom);
        cy = sample_t'($urandom);
      end
      send_sample(jitter(cx), jitter(cy));
    end
  endtask

  // long output hold-off while inputs keep coming, so the input stalls
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    while (!holding) @(posedge clk);
    repeat (12) send_sample(sample_t'($urandom), sample_t'($urandom));
    input_idle();
    while (holding) @(posedge clk);
  endtask

  // sender waits for every pending result before resuming
  task automatic test_drain_pause();
    input_idle();
    wait_drained();
    test_random_tracks(20);
  endtask

  task automatic test_steady_stream();
    no_idle = 1'b1;
    test_random_tracks(200);
  endtask

  initial begin
    errors     = 0;
    n_samples  = 0;
    n_filtered = 0;
    cycles     = 0;
    fill_level = 0;
    win_x      = '0;
    win_y      = '0;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    holding    = 1'b0;
    rst_n      = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_fill_and_extremes();
    test_random_tracks(700);
    test_output_backpressure();
    test_random_tracks(700);
    test_drain_pause();
    test_steady_stream();

    input_idle();
    wait_drained();
    repeat (DRAIN_LEN) @(posedge clk);
    if (filtered_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, filtered_q.size());
    end

    $display("covered %0d samples and %0d filtered outputs: window fill, rail values,",
             n_samples, n_filtered);
    $display("deviation ties, random tracks, long output stall, drain pause, no-idle stream");
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/wnm_pkg.sv
src/wnm_div.sv
src/wnm_lane.sv
src/window_nearest_to_mean_filter.sv
dv/testbench.sv
